FILE: hdl/first_fit_chunk_allocator_core_macros.svh
// assertion macros for the first-fit chunk allocator core
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FFCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FFCA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FFCA_ASSERT(lbl, prop, msg)
`define FFCA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hdl/ffca_pkg.sv
// types and constants shared by the first-fit chunk allocator
// no dependencies
package ffca_pkg;

  localparam int NUM_CHUNKS   = 1024;
  localparam int CHUNK_BYTES  = 32;
  localparam int CHUNK_SHIFT  = 5;
  localparam int HEADER_BYTES = 4;
  localparam int WORD_BITS    = 32;
  localparam int NUM_WORDS    = NUM_CHUNKS / WORD_BITS;
  localparam int IDX_W        = 10;
  localparam int WIDX_W       = 5;
  localparam int BIT_W        = 5;
  localparam int CNT_W        = 11;
  localparam int REQ_W        = 16;
  localparam int TOTAL_W      = 17;
  localparam int META_W       = CNT_W + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic             func;
    logic [REQ_W-1:0] request_bytes;
    logic [IDX_W-1:0] free_start_chunk;
  } ffca_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] start_chunk;
    logic [CNT_W-1:0] chunk_count;
    logic [CNT_W-1:0] chunks_in_use;
  } ffca_res_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
    logic [CNT_W-1:0] run;
  } ffca_scan_t;

endpackage

FILE: hdl/ffca_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ffca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/ffca_need.sv
// rounding unit: request plus header rounded up to whole chunks by a shift
// depends on ffca_pkg
module ffca_need import ffca_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [REQ_W-1:0]   req_bytes_i,
  output logic               done_o,
  output logic [TOTAL_W-1:0] need_o
);

  logic               done_q;
  logic [TOTAL_W-1:0] need_q;
  logic [TOTAL_W-1:0] sum;

  assign sum = TOTAL_W'(req_bytes_i) + TOTAL_W'(HEADER_BYTES + CHUNK_BYTES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      need_q <= sum >> CHUNK_SHIFT;
    end
  end

  assign done_o = done_q;
  assign need_o = need_q;

endmodule

FILE: hdl/ffca_word_scan.sv
// free-run search over one 32-chunk word of the used map
// depends on ffca_pkg
module ffca_word_scan import ffca_pkg::*; (
  input  logic [WORD_BITS-1:0] used_i,
  input  logic [WIDX_W-1:0]    widx_i,
  input  logic [CNT_W-1:0]     run_i,
  input  logic [CNT_W-1:0]     need_i,
  input  logic [CNT_W-1:0]     limit_i,
  output ffca_scan_t           scan_o
);

  logic [WORD_BITS-1:0] free_v;
  logic [WORD_BITS-1:0] hit_v;
  logic [CNT_W:0]       run_at [WORD_BITS];
  logic [BIT_W-1:0]     last;
  logic                 seen;
  logic [BIT_W-1:0]     pos;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      free_v[i] = !used_i[i] && ({1'b0, widx_i, BIT_W'(i)} < limit_i);
    end
    seen = 1'b0;
    last = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      seen = 1'b0;
      last = '0;
      for (int j = 0; j <= i; j++) begin
        if (!free_v[j]) begin
          seen = 1'b1;
          last = BIT_W'(j);
        end
      end
      run_at[i] = seen ? (CNT_W+1)'(i) - (CNT_W+1)'(last)
                       : (CNT_W+1)'(run_i) + (CNT_W+1)'(i) + (CNT_W+1)'(1);
      hit_v[i]  = run_at[i] >= {1'b0, need_i};
    end
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit_v[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  assign scan_o.hit = |hit_v;
  assign scan_o.pos = pos;
  assign scan_o.run = run_at[WORD_BITS-1][CNT_W-1:0];

endmodule

FILE: hdl/first_fit_chunk_allocator_core.sv
// first-fit chunk allocator core: sequencer, used map and run table memories
// depends on ffca_pkg, ffca_ram, ffca_need, ffca_word_scan and the macro header
//
// One request at a time; busy is high from the accepted transfer until the
// result strobe. After reset a clearing pass wipes the run table and used
// map, busy is high meanwhile. An allocate keeps busy high for a size
// rounding state, a scan of the used map a 32-chunk word at a time (up to
// 32 words), then a marking pass over each word the granted run spans (up
// to 32); it ends after rounding when the request exceeds the usable range.
// A free keeps busy high for a lookup state plus a marking pass over each
// word the run spans; a bad free ends after the lookup. The single used-map
// port makes scan and marking go a word at a time. The result is on res_o
// with a one-cycle done_o strobe in the cycle busy falls; it cannot be held off.
`include "first_fit_chunk_allocator_core_macros.svh"
module first_fit_chunk_allocator_core import ffca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ffca_req_t   req_i,
  output logic        done_o,
  output ffca_res_t   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_MARK  = 6'b010000,
    S_FREE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  usable_q, used_total_q, used_total_d;
  logic [WIDX_W-1:0] word_q, word_d;
  logic [CNT_W-1:0]  run_q, run_d, need_q, need_d, end_q, end_d;
  logic [IDX_W-1:0]  start_q, start_d, clr_q;
  logic              free_op_q, free_op_d;
  ffca_res_t         res_q, res_d;
  logic              done_q, done_d;

  logic [CNT_W-1:0]     limit;
  logic                 accept;
  logic                 div_done;
  logic [TOTAL_W-1:0]   div_need, need_fix;
  logic [WORD_BITS-1:0] map_rdata, map_wdata, mask;
  logic                 map_we;
  logic [WIDX_W-1:0]    map_waddr;
  logic [META_W-1:0]    meta_rdata, meta_wdata;
  logic                 meta_we;
  logic [IDX_W-1:0]     meta_waddr;
  ffca_scan_t           scan;
  logic [CNT_W-1:0]     found_end, last_idx, free_end;
  logic [CNT_W:0]       free_sum;

  function automatic logic [WIDX_W-1:0] last_scan_word(input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] top;
    top = lim - CNT_W'(1);
    return top[IDX_W-1:BIT_W];
  endfunction

  assign limit  = (usable_q > CNT_W'(NUM_CHUNKS)) ? CNT_W'(NUM_CHUNKS) : usable_q;
  assign accept = start && !busy;
  assign busy   = state_q != S_IDLE;

  ffca_need u_need (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && req_i.func == FUNC_ALLOC),
    .req_bytes_i(req_i.request_bytes),
    .done_o     (div_done),
    .need_o     (div_need)
  );

  ffca_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(word_d),
    .rdata_o(map_rdata)
  );

  ffca_ram #(.WIDTH(META_W), .DEPTH(NUM_CHUNKS)) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .raddr_i(req_i.free_start_chunk),
    .rdata_o(meta_rdata)
  );

  ffca_word_scan u_scan (
    .used_i (map_rdata),
    .widx_i (word_q),
    .run_i  (run_q),
    .need_i (need_q),
    .limit_i(limit),
    .scan_o (scan)
  );

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = ({1'b0, word_q, BIT_W'(i)} >= {1'b0, start_q}) &&
                ({1'b0, word_q, BIT_W'(i)} < end_q);
    end
  end

  assign need_fix  = (div_need == '0) ? TOTAL_W'(1) : div_need;
  assign found_end = {word_q, scan.pos} + CNT_W'(1);
  assign last_idx  = end_q - CNT_W'(1);
  assign free_sum  = {2'b0, start_q} + {1'b0, meta_rdata[CNT_W-1:0]};
  assign free_end  = (free_sum > (CNT_W+1)'(NUM_CHUNKS)) ? CNT_W'(NUM_CHUNKS)
                                                         : free_sum[CNT_W-1:0];

  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    run_d        = run_q;
    need_d       = need_q;
    end_d        = end_q;
    start_d      = start_q;
    free_op_d    = free_op_q;
    used_total_d = used_total_q;
    res_d        = res_q;
    done_d       = 1'b0;
    map_we       = 1'b0;
    map_waddr    = word_q;
    map_wdata    = free_op_q ? (map_rdata & ~mask) : (map_rdata | mask);
    meta_we      = 1'b0;
    meta_waddr   = start_q;
    meta_wdata   = '0;
    unique case (state_q)
      S_CLEAR: begin
        map_we     = 1'b1;
        map_waddr  = clr_q[WIDX_W-1:0];
        map_wdata  = '0;
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        if (clr_q == IDX_W'(NUM_CHUNKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          start_d = req_i.free_start_chunk;
          state_d = (req_i.func == FUNC_ALLOC) ? S_DIV : S_FREE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (need_fix > TOTAL_W'(limit)) begin
            res_d   = '{ST_NO_SPACE, '0, '0, used_total_q};
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            need_d  = need_fix[CNT_W-1:0];
            word_d  = '0;
            run_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan.hit) begin
          start_d    = IDX_W'(found_end - need_q);
          end_d      = found_end;
          word_d     = start_d[IDX_W-1:BIT_W];
          free_op_d  = 1'b0;
          meta_we    = 1'b1;
          meta_waddr = start_d;
          meta_wdata = {1'b1, need_q};
          state_d    = S_MARK;
        end else if (word_q == last_scan_word(limit)) begin
          res_d   = '{ST_NO_SPACE, '0, '0, used_total_q};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          word_d = word_q + WIDX_W'(1);
          run_d  = scan.run;
        end
      end
      S_FREE: begin
        if (!meta_rdata[META_W-1]) begin
          res_d   = '{ST_BAD_FREE, start_q, '0, used_total_q};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          need_d     = meta_rdata[CNT_W-1:0];
          end_d      = free_end;
          word_d     = start_q[IDX_W-1:BIT_W];
          free_op_d  = 1'b1;
          meta_we    = 1'b1;
          meta_wdata = '0;
          state_d    = S_MARK;
        end
      end
      S_MARK: begin
        map_we = 1'b1;
        if (word_q == last_idx[IDX_W-1:BIT_W]) begin
          if (free_op_q) begin
            used_total_d = (used_total_q >= need_q) ? used_total_q - need_q : '0;
          end else begin
            used_total_d = used_total_q + need_q;
          end
          res_d   = '{ST_OK, start_q, need_q, used_total_d};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          word_d = word_q + WIDX_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      used_total_q <= '0;
      usable_q     <= CNT_W'(NUM_CHUNKS);
      done_q       <= 1'b0;
      free_op_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_total_q <= used_total_d;
      done_q       <= done_d;
      free_op_q    <= free_op_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (psel && penable && pwrite && !paddr[2]) begin
        usable_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    run_q   <= run_d;
    need_q  <= need_d;
    end_q   <= end_d;
    start_q <= start_d;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - CNT_W){1'b0}}, usable_q};

  `FFCA_ASSERT(a_done_single, done_o |=> !done_o, "result strobe held for two cycles")
  `FFCA_ASSERT(a_busy_after_accept, accept |=> busy, "accepted transfer did not raise busy")
  `FFCA_ASSERT_NEVER(a_total_range, used_total_q > CNT_W'(NUM_CHUNKS), "chunk count overflow")
  `FFCA_ASSERT_NEVER(a_fail_count, done_o && res_o.status == ST_NO_SPACE && res_o.chunk_count != '0, "failed allocate reports a length")

endmodule

FILE: bench/tb.sv
// testbench for first_fit_chunk_allocator_core: random and directed allocate/free traffic
// depends on ffca_pkg and the core rtl; a scoreboard class predicts each result transfer
module tb;
  import ffca_pkg::*;

  class alloc_scoreboard;
    bit              used_map [NUM_CHUNKS];
    bit              run_head [NUM_CHUNKS];
    int unsigned     run_len  [NUM_CHUNKS];
    int unsigned     in_use;
    int unsigned     usable;
    ffca_res_t       pending[$];
    int unsigned     errors;
    int unsigned     n_ok, n_nospace, n_badfree;

    function new();
      foreach (used_map[i]) begin
        used_map[i] = 0;
        run_head[i] = 0;
        run_len[i]  = 0;
      end
      in_use = 0;
      usable = 1024;
      errors = 0;
    endfunction

    function void note_request(ffca_req_t r);
      ffca_res_t   e;
      int unsigned need, lim, run, s;
      bit          found;
      e = '0;
      if (r.func == FUNC_ALLOC) begin
        need = (int'(r.request_bytes) + HEADER_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
        if (need == 0) need = 1;
        lim = (usable > NUM_CHUNKS) ? NUM_CHUNKS : usable;
        found = 0;
        run = 0;
        if (need <= lim) begin
          for (int c = 0; c < lim && !found; c++) begin
            if (used_map[c]) run = 0;
            else begin
              run++;
              if (run == need) begin
                found = 1;
                s = c + 1 - need;
              end
            end
          end
        end
        if (found) begin
          for (int i = s; i < s + need; i++) used_map[i] = 1;
          run_head[s] = 1;
          run_len[s]  = need;
          in_use += need;
          e.status = ST_OK;
          e.start_chunk = IDX_W'(s);
          e.chunk_count = CNT_W'(need);
        end else e.status = ST_NO_SPACE;
      end else begin
        e.start_chunk = r.free_start_chunk;
        if (run_head[r.free_start_chunk]) begin
          s = r.free_start_chunk;
          for (int i = s; i < s + run_len[s] && i < NUM_CHUNKS; i++) used_map[i] = 0;
          run_head[s] = 0;
          in_use = (in_use >= run_len[s]) ? in_use - run_len[s] : 0;
          e.status = ST_OK;
          e.chunk_count = CNT_W'(run_len[s]);
        end else e.status = ST_BAD_FREE;
      end
      e.chunks_in_use = CNT_W'(in_use);
      pending.push_back(e);
    endfunction

    function void check_result(ffca_res_t a);
      ffca_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      case (a.status)
        ST_OK:       n_ok++;
        ST_NO_SPACE: n_nospace++;
        default:     n_badfree++;
      endcase
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.start_chunk !== e.start_chunk) begin
        $display("%0t: start_chunk expected %0d actual %0d", $time, e.start_chunk,
                 a.start_chunk);
        errors++;
      end
      if (a.chunk_count !== e.chunk_count) begin
        $display("%0t: chunk_count expected %0d actual %0d", $time, e.chunk_count,
                 a.chunk_count);
        errors++;
      end
      if (a.chunks_in_use !== e.chunks_in_use) begin
        $display("%0t: chunks_in_use expected %0d actual %0d", $time, e.chunks_in_use,
                 a.chunks_in_use);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  ffca_req_t   req_i = '0;
  logic        done_o;
  ffca_res_t   res_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard sb = new();
  int unsigned     idle_pct = 23;
  int unsigned     live_starts[$];

  first_fit_chunk_allocator_core dut (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  task automatic send_request(logic fn, int unsigned bytes, int unsigned fstart);
    ffca_req_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    r.func = fn;
    r.request_bytes = REQ_W'(bytes);
    r.free_start_chunk = IDX_W'(fstart);
    start <= 1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic alloc_req(int unsigned bytes);
    send_request(FUNC_ALLOC, bytes, $urandom_range(1023));
  endtask

  task automatic free_req(int unsigned c);
    send_request(FUNC_FREE, $urandom_range(65535), c);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_usable(int unsigned v);
    drain();
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.usable = v & 32'h7ff;
    @(posedge clk_i);
  endtask

  task automatic free_all_heads();
    for (int c = 0; c < NUM_CHUNKS; c++)
      if (sb.run_head[c]) free_req(c);
  endtask

  task automatic random_phase(int unsigned n, int unsigned max_bytes);
    int unsigned k, c, sel;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 50) begin
        sel = $urandom_range(9);
        alloc_req(sel == 0 ? $urandom_range(65535) : $urandom_range(max_bytes));
      end else if (k < 85) begin
        live_starts.delete();
        for (c = 0; c < NUM_CHUNKS; c++) if (sb.run_head[c]) live_starts.push_back(c);
        if (live_starts.size() != 0)
          free_req(live_starts[$urandom_range(live_starts.size() - 1)]);
        else free_req($urandom_range(1023));
      end else free_req($urandom_range(1023));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // directed: field extremes, both operations, header edge, no space, bad frees
    alloc_req(0);
    alloc_req(28);
    alloc_req(29);
    alloc_req(65535);
    alloc_req(32764);
    alloc_req(1000);
    free_req(0);
    free_req(0);
    free_req(1023);
    free_req(1);
    alloc_req(1);
    alloc_req(60);
    free_req(3);
    alloc_req(10);
    write_usable(0);
    alloc_req(0);
    free_req(1);
    write_usable(1);
    alloc_req(0);
    alloc_req(0);
    write_usable(2047);
    alloc_req(65535);
    free_all_heads();
    drain();

    random_phase(400, 2000);
    idle_pct = 0;
    random_phase(150, 600);
    idle_pct = 23;
    drain();
    write_usable(1);
    random_phase(60, 40);
    write_usable(37);
    random_phase(200, 300);
    write_usable(1024);
    random_phase(200, 8000);
    write_usable(1025);
    random_phase(150, 1500);
    write_usable(2047);
    random_phase(140, 65535);

    drain();
    $display("covered %0d ok, %0d no-space and %0d bad-free results over five range settings",
             sb.n_ok, sb.n_nospace, sb.n_badfree);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: first_fit_chunk_allocator_core.f
+incdir+hdl
hdl/ffca_pkg.sv
hdl/ffca_ram.sv
hdl/ffca_need.sv
hdl/ffca_word_scan.sv
hdl/first_fit_chunk_allocator_core.sv
bench/tb.sv
